@@ design/mlp_4_4_1_sigmoid_inference_macros.svh @@
// ---------------------------------------------------------------------------
// mlp_4_4_1_sigmoid_inference_macros.svh
// Assertion macros shared by the perceptron inference block.
// ---------------------------------------------------------------------------
`ifndef MLP_4_4_1_SIGMOID_INFERENCE_MACROS_SVH
`define MLP_4_4_1_SIGMOID_INFERENCE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define MLP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlp441 check failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define MLP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlp441 check failed");

`endif

@@ design/mlp441_pkg.sv @@
// ---------------------------------------------------------------------------
// mlp441_pkg
// Sizes, fixed-point formats, reset weight pattern and sigmoid table of the
// 4-4-1 perceptron inference block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlp441_pkg;

	// Network shape and number formats
	localparam int FEAT_CNT    = 4;
	localparam int NUM_HIDDEN  = 4;
	localparam int FRAC_BITS   = 12;
	localparam int OUT_FRAC    = 16;
	localparam int WORD_W      = 16;
	localparam int STRIDE      = ((FEAT_CNT > NUM_HIDDEN) ? FEAT_CNT : NUM_HIDDEN) + 1;
	localparam int STORE_DEPTH = (NUM_HIDDEN + 1) * STRIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SLOT_W      = $clog2(STRIDE);
	localparam int NEU_W       = $clog2(NUM_HIDDEN + 1);
	localparam int FEAT_SEL_W  = $clog2(FEAT_CNT);
	localparam int HID_SEL_W   = $clog2(NUM_HIDDEN);
	localparam int ACC_W       = 37;
	localparam int TABLE_SIZE  = 256;
	localparam int TAB_W       = $clog2(TABLE_SIZE);

	// Opcodes carried in tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_INFER = 1'b1;

	// Reset pattern coefficients in Q.FRAC_BITS
	localparam int ONE_Q = 1 << FRAC_BITS;
	localparam int W0_Q  = ONE_Q / 2;
	localparam int DN_Q  = (ONE_Q + 50) / 100;
	localparam int DI_Q  = (ONE_Q + 100) / 200;
	localparam int B0_Q  = (ONE_Q + 5) / 10;

	// e^-1/32 and e^-1/16 in Q0.32
	localparam logic [63:0] EXP_HALF_STEP = 64'd4162825041;
	localparam logic [63:0] EXP_STEP      = 64'd4034748382;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [WORD_W-1:0] sig_tab_t [TABLE_SIZE];
	typedef logic [WORD_W-1:0] winit_t [STORE_DEPTH];

	// Request from the port logic to the sequencer
	typedef struct packed {
		logic                             start;
		logic                             take;
		logic [FEAT_CNT-1:0][WORD_W-1:0]  feat;
	} mlp_req_t;

	// Status from the sequencer back to the port logic
	typedef struct packed {
		logic        idle;
		logic        done;
		word_t       prediction;
	} mlp_rsp_t;

	// Weight store contents after reset
	function automatic winit_t build_winit();
		winit_t tab;
		int     w;
		for (int n = 0; n <= NUM_HIDDEN; n++) begin
			for (int i = 0; i < STRIDE - 1; i++) begin
				w = W0_Q + DN_Q * n - DI_Q * i;
				tab[n * STRIDE + i] = w[WORD_W-1:0];
			end
			w = B0_Q + DN_Q * n;
			tab[n * STRIDE + STRIDE - 1] = w[WORD_W-1:0];
		end
		return tab;
	endfunction

	// Sigmoid at bin centers, Q0.16; evaluated at elaboration only
	function automatic sig_tab_t build_sig_table();
		sig_tab_t    tab;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] q;
		logic [63:0] prod;
		logic [15:0] s;
		e = EXP_HALF_STEP;
		for (int k = 0; k < TABLE_SIZE / 2; k++) begin
			d   = (64'd1 << 32) + e;
			num = (64'd1 << 48) + (d >> 1);
			rem = '0;
			q   = '0;
			// restoring long division
			for (int b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= d) begin
					rem  = rem - d;
					q[b] = 1'b1;
				end
			end
			s = (q > 64'd65535) ? 16'hFFFF : q[15:0];
			tab[TABLE_SIZE / 2 + k]     = s;
			tab[TABLE_SIZE / 2 - 1 - k] = 16'(17'h10000 - {1'b0, s});
			prod = e * EXP_STEP + (64'd1 << 31);
			e    = prod >> 32;
		end
		return tab;
	endfunction

	localparam winit_t   WINIT     = build_winit();
	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

@@ design/mlp441_wmem.sv @@
// ---------------------------------------------------------------------------
// mlp441_wmem
// Weight store: one write port, one registered read port. Entries never
// written since reset read back as the reset weight pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mlp_4_4_1_sigmoid_inference_macros.svh"

module mlp441_wmem
	import mlp441_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  word_t             wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output word_t             rdata
);

	word_t                  mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	word_t                  rdata_q;

	// Written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, reset pattern for unwritten entries
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem_q[raddr] : WINIT[raddr];
		end
	end

	assign rdata = rdata_q;

	`MLP_ASSERT_NOW(a_raddr_range, re, raddr < ADDR_W'(STORE_DEPTH))
	`MLP_ASSERT_NOW(a_no_rw_overlap, we, !re)

endmodule

@@ design/mlp441_core.sv @@
// ---------------------------------------------------------------------------
// mlp441_core
// Sequencer and shared multiply-accumulate: streams weight words out of the
// store, accumulates one neuron at a time and maps sums through the sigmoid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mlp_4_4_1_sigmoid_inference_macros.svh"

module mlp441_core
	import mlp441_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mlp_req_t          req,
	output mlp_rsp_t          rsp,
	output logic              re,
	output logic [ADDR_W-1:0] raddr,
	input  word_t             rdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RUN_H  = 3'd1;
	localparam logic [2:0] ST_WAIT_H = 3'd2;
	localparam logic [2:0] ST_RUN_O  = 3'd3;
	localparam logic [2:0] ST_WAIT_O = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	localparam logic [SLOT_W-1:0] FIRST_SLOT = '0;
	localparam logic [SLOT_W-1:0] BIAS_SLOT  = SLOT_W'(STRIDE - 1);
	localparam logic [NEU_W-1:0]  LAST_HID   = NEU_W'(NUM_HIDDEN - 1);
	localparam logic signed [ACC_W-1:0] HID_OFF = ACC_W'(64'sd1 <<< (2 * FRAC_BITS + 3));
	localparam logic signed [ACC_W-1:0] OUT_OFF =
		ACC_W'(64'sd1 <<< (FRAC_BITS + OUT_FRAC + 3));
	localparam int HID_SHIFT = 2 * FRAC_BITS - 4;
	localparam int OUT_SHIFT = FRAC_BITS + OUT_FRAC - 4;

	typedef struct packed {
		logic              outl;
		logic [NEU_W-1:0]  neuron;
		logic [SLOT_W-1:0] slot;
	} tag_t;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [NEU_W-1:0]        neu_q;
	word_t                   feat_q [FEAT_CNT];
	word_t                   hid_q [NUM_HIDDEN];
	word_t                   pred_q;
	logic                    issue;
	logic                    v_s1, v_s2, v_s3;
	tag_t                    tag_s1, tag_s2, tag_s3;
	logic signed [ACC_W-1:0] term_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] sum_s3;

	logic signed [WORD_W:0]     opnd;
	logic signed [2*WORD_W:0]   prod;
	logic signed [ACC_W-1:0]    bias_term;
	logic signed [ACC_W-1:0]    lk_t;
	logic signed [ACC_W-1:0]    lk_sh;
	logic [TAB_W-1:0]           lk_idx;
	word_t                      lk_sig;
	logic                       hid_last_done;
	logic                       out_done;

	assign issue = (state_q == ST_RUN_H) || (state_q == ST_RUN_O);
	assign re    = issue;
	assign raddr = addr_q;

	assign hid_last_done = v_s3 && !tag_s3.outl && (tag_s3.neuron == LAST_HID);
	assign out_done      = v_s3 && tag_s3.outl;

	// Sequencer and read address walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			slot_q  <= '0;
			neu_q   <= '0;
		end else begin
			if (issue) begin
				addr_q <= addr_q + 1'b1;
				if (slot_q == BIAS_SLOT) begin
					slot_q <= FIRST_SLOT;
					neu_q  <= neu_q + 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						addr_q  <= '0;
						slot_q  <= FIRST_SLOT;
						neu_q   <= '0;
						state_q <= ST_RUN_H;
					end
				end
				ST_RUN_H: begin
					if (slot_q == BIAS_SLOT && neu_q == LAST_HID) begin
						state_q <= ST_WAIT_H;
					end
				end
				ST_WAIT_H: begin
					if (hid_last_done) begin
						state_q <= ST_RUN_O;
					end
				end
				ST_RUN_O: begin
					if (slot_q == BIAS_SLOT) begin
						state_q <= ST_WAIT_O;
					end
				end
				ST_WAIT_O: begin
					if (out_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (req.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Feature latch
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.start) begin
			for (int i = 0; i < FEAT_CNT; i++) begin
				feat_q[i] <= req.feat[i];
			end
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (tag_s2.slot == BIAS_SLOT);
		end
	end

	// Stage 1: weight word is back, multiply by feature or hidden value, or scale a bias word
	always_comb begin
		if (tag_s1.outl) begin
			opnd = $signed({1'b0, hid_q[tag_s1.slot[HID_SEL_W-1:0]]});
		end else begin
			opnd = $signed({feat_q[tag_s1.slot[FEAT_SEL_W-1:0]][WORD_W-1],
				feat_q[tag_s1.slot[FEAT_SEL_W-1:0]]});
		end
		prod = (2*WORD_W+1)'($signed(rdata)) * (2*WORD_W+1)'(opnd);
		if (tag_s1.outl) begin
			bias_term = ACC_W'($signed(rdata)) <<< OUT_FRAC;
		end else begin
			bias_term = ACC_W'($signed(rdata)) <<< FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.outl   <= (state_q == ST_RUN_O);
		tag_s1.neuron <= neu_q;
		tag_s1.slot   <= slot_q;
		tag_s2        <= tag_s1;
		term_s2       <= (tag_s1.slot == BIAS_SLOT) ? bias_term : ACC_W'(prod);
	end

	// Stage 2: accumulate, hand the finished neuron sum on
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (tag_s2.slot == FIRST_SLOT) begin
				acc_q <= term_s2;
			end else begin
				acc_q <= acc_q + term_s2;
			end
			if (tag_s2.slot == BIAS_SLOT) begin
				sum_s3 <= acc_q + term_s2;
				tag_s3 <= tag_s2;
			end
		end
	end

	// Stage 3: sigmoid table index, saturated to the table range
	always_comb begin
		lk_t = sum_s3 + (tag_s3.outl ? OUT_OFF : HID_OFF);
		if (tag_s3.outl) begin
			lk_sh = lk_t >>> OUT_SHIFT;
		end else begin
			lk_sh = lk_t >>> HID_SHIFT;
		end
		if (lk_t[ACC_W-1]) begin
			lk_idx = '0;
		end else if (|lk_sh[ACC_W-1:TAB_W]) begin
			lk_idx = '1;
		end else begin
			lk_idx = lk_sh[TAB_W-1:0];
		end
		lk_sig = SIG_TABLE[lk_idx];
	end

	always_ff @(posedge clk) begin
		if (v_s3 && !tag_s3.outl) begin
			hid_q[tag_s3.neuron[HID_SEL_W-1:0]] <= lk_sig;
		end
		if (out_done) begin
			pred_q <= lk_sig;
		end
	end

	assign rsp.idle       = (state_q == ST_IDLE);
	assign rsp.done       = (state_q == ST_DONE);
	assign rsp.prediction = pred_q;

	`MLP_ASSERT_NOW(a_out_sum_while_waiting, out_done, state_q == ST_WAIT_O)
	`MLP_ASSERT_NOW(a_hid_sum_while_waiting, hid_last_done, state_q == ST_WAIT_H)
	`MLP_ASSERT_NOW(a_idle_pipe_empty, state_q == ST_IDLE, !v_s1 && !v_s2 && !v_s3)

endmodule

@@ design/mlp_4_4_1_sigmoid_inference.sv @@
// ---------------------------------------------------------------------------
// mlp_4_4_1_sigmoid_inference
// 4-input, 4-hidden, 1-output perceptron forward pass with sigmoid outputs
// and a programmable decision threshold.
// ---------------------------------------------------------------------------
// An item is accepted only while the block is idle, and after an inference
// item no new item is accepted until its result has moved to the output
// register. The 25 weight words of an inference are read one per cycle
// through the single read port of the weight store and folded through one
// shared multiply-accumulate, with a short drain after the hidden layer and
// after the output neuron. A weight write item produces no result. A finished
// result sits in the output register while the next item is already being
// processed. The weight store needs no clearing pass: it comes out of reset
// holding its default pattern.
`timescale 1ns / 1ps
`include "mlp_4_4_1_sigmoid_inference_macros.svh"

module mlp_4_4_1_sigmoid_inference
	import mlp441_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // weight_index[4:0], weight_value[20:5], feature_0[36:21],
	                              // feature_1[52:37], feature_2[68:53], feature_3[84:69]
	input  logic [0:0]  s_tuser,  // opcode[0]
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // prediction[15:0], decision[16]
	// threshold register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              in_acc;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	mlp_req_t          req;
	mlp_rsp_t          rsp;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	word_t             rd_data;
	word_t             thr_q;
	logic              m_valid_q;
	word_t             pred_q;
	logic              dec_q;
	logic              out_free;

	assign s_tready = rsp.idle;
	assign in_acc   = s_tvalid && s_tready;
	assign wr_addr  = s_tdata[ADDR_W-1:0];
	assign wr_en    = in_acc && (s_tuser[0] == OP_WRITE) && (wr_addr < ADDR_W'(STORE_DEPTH));

	// Requests toward the sequencer
	assign out_free  = !m_valid_q || m_tready;
	assign req.start = in_acc && (s_tuser[0] == OP_INFER);
	assign req.take  = rsp.done && out_free;
	assign req.feat[0] = s_tdata[36:21];
	assign req.feat[1] = s_tdata[52:37];
	assign req.feat[2] = s_tdata[68:53];
	assign req.feat[3] = s_tdata[84:69];

	mlp441_wmem u_wmem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (wr_en),
		.waddr  (wr_addr),
		.wdata  (s_tdata[20:5]),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (rd_data)
	);

	mlp441_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.re     (rd_en),
		.raddr  (rd_addr),
		.rdata  (rd_data)
	);

	// Threshold register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'h8000;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (req.take) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.take) begin
			pred_q <= rsp.prediction;
			dec_q  <= (rsp.prediction > thr_q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, dec_q, pred_q};

	`MLP_ASSERT_NEXT(a_infer_goes_busy, req.start, !s_tready)

endmodule

@@ verif/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-4-1 perceptron inference block. A local
// forward-pass predictor mirrors the weight store, the sigmoid table and
// the decision threshold. Every accepted inference item queues the expected
// prediction and decision flag. Every accepted result is checked against the
// oldest queued entry. Directed items cover the reset weights, extreme
// features and weights, ignored write indexes and the threshold edge. Random
// items with random source gaps and sink stalls follow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import mlp441_pkg::*;

	localparam int          CLK_HALF     = 6;
	localparam int          RESET_CYCLES = 11;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          SETTLE       = 40;
	localparam int          MAX_IDLE     = 16;
	localparam int          RANDOM_ITEMS = 1400;
	localparam int          CHUNK        = 200;
	localparam int          OUT_BIAS     = NUM_HIDDEN * STRIDE + STRIDE - 1;
	localparam logic [4:0]  TOP_INDEX    = 5'h1F;
	localparam logic [63:0] EXP_M1_32    = 64'd4162825041;  // e^-1/32, Q0.32
	localparam logic [63:0] EXP_M1_16    = 64'd4034748382;  // e^-1/16, Q0.32

	typedef logic [3:0][WORD_W-1:0] feat_vec_t;
	typedef struct packed {
		logic              dec;
		logic [WORD_W-1:0] pred;
	} mlp_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;   // weight_index, weight_value, feature_0..feature_3
	logic [0:0]  s_tuser;   // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // prediction, decision
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Predictor state; newest expectation at the front, oldest at the back
	logic [WORD_W-1:0] weight_mirror [STORE_DEPTH];
	logic [WORD_W-1:0] sig_lut [TABLE_SIZE];
	logic [WORD_W-1:0] threshold_mirror;
	mlp_result_t       pending_results [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int src_max_gap;
	int snk_max_stall;

	mlp_4_4_1_sigmoid_inference u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// z with frac fractional bits -> table entry, z saturated to [-8, 8)
	function automatic logic [WORD_W-1:0] sig_of(longint acc, int frac);
		longint t;
		longint bin;
		t = acc + (longint'(1) << (frac + 3));
		if (t < 0)
			return sig_lut[0];
		bin = t >>> (frac - 4);
		if (bin > TABLE_SIZE - 1)
			bin = TABLE_SIZE - 1;
		return sig_lut[bin];
	endfunction

	// Hidden layer in Q.2F, output neuron in Q.(F+16)
	function automatic mlp_result_t forward_pass(feat_vec_t feat);
		longint            acc;
		logic [WORD_W-1:0] hid [NUM_HIDDEN];
		mlp_result_t       r;
		for (int n = 0; n < NUM_HIDDEN; n++) begin
			acc = longint'($signed(weight_mirror[n * STRIDE + STRIDE - 1])) *
			      (longint'(1) << FRAC_BITS);
			for (int i = 0; i < FEAT_CNT; i++)
				acc += longint'($signed(weight_mirror[n * STRIDE + i])) *
				       longint'($signed(feat[i]));
			hid[n] = sig_of(acc, 2 * FRAC_BITS);
		end
		acc = longint'($signed(weight_mirror[OUT_BIAS])) * (longint'(1) << 16);
		for (int i = 0; i < NUM_HIDDEN; i++)
			acc += longint'($signed(weight_mirror[NUM_HIDDEN * STRIDE + i])) *
			       longint'(hid[i]);
		r.pred = sig_of(acc, FRAC_BITS + 16);
		r.dec  = (r.pred > threshold_mirror);
		return r;
	endfunction

	// Q4.12 value: full range, within +-2.0 or within +-0.25
	function automatic logic [WORD_W-1:0] rand_q12();
		int pick;
		pick = $urandom_range(0, 3);
		case (pick)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 2047) - 1024);
			default: return 16'($urandom_range(0, 16383) - 8192);
		endcase
	endfunction

	function automatic feat_vec_t rand_features();
		feat_vec_t f;
		for (int i = 0; i < 4; i++)
			f[i] = rand_q12();
		return f;
	endfunction

	// Send one item after a random gap; tvalid stays high if the next gap is zero
	task automatic send_item(input logic op, input logic [4:0] idx,
	                         input logic [WORD_W-1:0] val, input feat_vec_t feat);
		int gap;
		gap = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {3'b000, feat, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_WRITE) begin
			if (idx < STORE_DEPTH)
				weight_mirror[idx] = val;
		end else begin
			pending_results.push_front(forward_pass(feat));
		end
	endtask

	task automatic send_infer(input feat_vec_t feat);
		send_item(OP_INFER, 5'($urandom), 16'($urandom), feat);
	endtask

	task automatic send_write(input logic [4:0] idx, input logic [WORD_W-1:0] val);
		send_item(OP_WRITE, idx, val, rand_features());
	endtask

	// Threshold write once the block has drained
	task automatic write_threshold(input logic [WORD_W-1:0] level);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= level;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		threshold_mirror = level;
	endtask

	// Reset weights with zero, saturating and mixed features
	task automatic test_default_weights();
		send_infer('0);
		send_infer({4{16'h7FFF}});
		send_infer({4{16'h8000}});
		send_infer({16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF});
		send_infer({16'h1000, 16'hF000, 16'h0800, 16'hF800});
	endtask

	// Extreme weights, ignored indexes, output neuron driven to both rails
	task automatic test_weight_writes();
		logic [WORD_W-1:0] saved_bias;
		send_write(5'd0, 16'h7FFF);
		send_write(5'(STRIDE - 1), 16'h8000);
		send_write(5'(STORE_DEPTH), 16'h1234);
		send_write(TOP_INDEX, 16'hFFFF);
		send_infer({4{16'h4000}});
		saved_bias = weight_mirror[OUT_BIAS];
		send_write(5'(OUT_BIAS), 16'h7FFF);
		send_infer('0);
		send_write(5'(OUT_BIAS), 16'h8000);
		send_infer('0);
		send_write(5'(OUT_BIAS), saved_bias);
	endtask

	// Threshold at both extremes and exactly at the prediction
	task automatic test_threshold();
		mlp_result_t r;
		write_threshold(16'h0000);
		send_infer('0);
		write_threshold(16'hFFFF);
		send_infer('0);
		r = forward_pass('0);
		write_threshold(r.pred);
		send_infer('0);
		if (r.pred != '0) begin
			write_threshold(r.pred - 1'b1);
			send_infer('0);
		end
	endtask

	// Random traffic in chunks, a new threshold and idling mode per chunk
	task automatic test_random();
		logic [WORD_W-1:0] level;
		logic              op;
		logic [4:0]        idx;
		for (int c = 0; c < RANDOM_ITEMS / CHUNK; c++) begin
			case (c)
				0: level = 16'h0000;
				1: level = 16'hFFFF;
				2: level = 16'h8000;
				default: level = 16'($urandom);
			endcase
			write_threshold(level);
			src_max_gap   = (c % 3 == 2) ? 0 : MAX_IDLE;
			snk_max_stall = (c % 3 == 2) ? 0 : MAX_IDLE;
			for (int k = 0; k < CHUNK; k++) begin
				op  = ($urandom_range(0, 3) != 0) ? OP_INFER : OP_WRITE;
				idx = ($urandom_range(0, 7) == 0) ?
				      5'($urandom_range(STORE_DEPTH, 31)) :
				      5'($urandom_range(0, STORE_DEPTH - 1));
				send_item(op, idx, rand_q12(), rand_features());
			end
		end
		src_max_gap   = MAX_IDLE;
		snk_max_stall = MAX_IDLE;
	endtask

	// Result sink with random stalls
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = (snk_max_stall == 0) ? 0 : $urandom_range(0, snk_max_stall);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		mlp_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h",
				         $time, m_tdata[16:0]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_back();
				if (m_tdata[15:0] !== want.pred) begin
					$display("%0t: prediction expected %h actual %h",
					         $time, want.pred, m_tdata[15:0]);
					mismatch_count++;
				end
				if (m_tdata[16] !== want.dec) begin
					$display("%0t: decision expected %b actual %b",
					         $time, want.dec, m_tdata[16]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : main_seq
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] s;
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		src_max_gap   = MAX_IDLE;
		snk_max_stall = MAX_IDLE;

		// sigmoid at bin centers: upper half from e^-x, lower half mirrored
		e = EXP_M1_32;
		for (int k = 0; k < TABLE_SIZE / 2; k++) begin
			d = (64'd1 << 32) + e;
			s = ((64'd1 << 48) + d / 2) / d;
			if (s > 64'd65535)
				s = 64'd65535;
			sig_lut[TABLE_SIZE / 2 + k]     = s[15:0];
			sig_lut[TABLE_SIZE / 2 - 1 - k] = 16'(64'd65536 - s);
			e = (e * EXP_M1_16 + (64'd1 << 31)) >> 32;
		end

		// weight store after reset
		for (int n = 0; n <= NUM_HIDDEN; n++) begin
			for (int i = 0; i < STRIDE - 1; i++)
				weight_mirror[n * STRIDE + i] =
					16'(W0_Q + DN_Q * n - DI_Q * i);
			weight_mirror[n * STRIDE + STRIDE - 1] = 16'(B0_Q + DN_Q * n);
		end
		threshold_mirror = 16'h8000;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_weights();
		test_weight_writes();
		test_threshold();
		test_random();

		// drain
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
